### sv/sem_pkg.sv
// Shared types, constants and helpers for the stack expression machine.
// Used by sem_alu and stack_expression_machine_core; no dependencies.
`timescale 1ns / 1ps

package sem_pkg;

    // datapath and storage sizes
    localparam int DATA_W      = 32;
    localparam int STEP_W      = $clog2(DATA_W);
    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
    localparam int VAR_COUNT   = 26;
    localparam int VAR_IDX_W   = 5;
    localparam int VAR_AW      = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

    // stream payload layout
    localparam int ACTION_W = 4;
    localparam int ERR_W    = 3;
    localparam int IN_W     = ((DATA_W + VAR_IDX_W + 7) / 8) * 8;
    localparam int OUT_RAW  = DATA_W + 1 + ERR_W + STACK_CW;
    localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

    localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_LIT = 4'd0,
        ACT_PUSH_VAR = 4'd1,
        ACT_STORE    = 4'd2,
        ACT_ADD      = 4'd3,
        ACT_SUB      = 4'd4,
        ACT_MUL      = 4'd5,
        ACT_DIV      = 4'd6,
        ACT_GT       = 4'd7,
        ACT_LT       = 4'd8,
        ACT_LE       = 4'd9,
        ACT_GE       = 4'd10,
        ACT_EQ       = 4'd11,
        ACT_NE       = 4'd12,
        ACT_TEST     = 4'd13,
        ACT_POP      = 4'd14,
        ACT_PEEK     = 4'd15
    } t_action;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_UNDER    = 3'd1,
        ERR_OVER     = 3'd2,
        ERR_DIV_ZERO = 3'd3,
        ERR_DIV_OVF  = 3'd4
    } t_err;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_GT,
        ALU_LT,
        ALU_LE,
        ALU_GE,
        ALU_EQ,
        ALU_NE
    } t_alu_op;

    typedef enum logic [2:0] {
        A_IDLE,
        A_SIMPLE,
        A_MUL,
        A_ABS_B,
        A_ABS_A,
        A_DIV,
        A_SIGN
    } t_alu_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_READ_A,
        S_READ_B,
        S_ALU,
        S_DONE
    } t_state;

    // sequencer to alu
    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    // alu to sequencer
    typedef struct packed {
        logic done;
        t_err err;
    } t_alu_rsp;

    // binary action to alu operation
    function automatic t_alu_op action_to_op(input t_action act);
        t_alu_op op;
        unique case (act)
            ACT_SUB: op = ALU_SUB;
            ACT_MUL: op = ALU_MUL;
            ACT_DIV: op = ALU_DIV;
            ACT_GT:  op = ALU_GT;
            ACT_LT:  op = ALU_LT;
            ACT_LE:  op = ALU_LE;
            ACT_GE:  op = ALU_GE;
            ACT_EQ:  op = ALU_EQ;
            ACT_NE:  op = ALU_NE;
            default: op = ALU_ADD;
        endcase
        return op;
    endfunction

endpackage

### sv/sem_alu.sv
// Shared iterative arithmetic unit: one 33-bit adder reused for add, subtract,
// compares, shift-add multiply and restoring divide. Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sem_pkg::t_alu_req          i_req,
    input  logic [sem_pkg::DATA_W-1:0] i_a,       // right operand (popped first)
    input  logic [sem_pkg::DATA_W-1:0] i_b,       // left operand
    output sem_pkg::t_alu_rsp          o_rsp,
    output logic [sem_pkg::DATA_W-1:0] o_result
);

    sem_pkg::t_alu_state        r_st, n_st;
    sem_pkg::t_alu_op           r_op, n_op;
    logic [sem_pkg::DATA_W-1:0] r_x, n_x;       // left / multiplier / quotient
    logic [sem_pkg::DATA_W-1:0] r_y, n_y;       // right / multiplicand / divisor
    logic [sem_pkg::DATA_W-1:0] r_acc, n_acc;   // product or remainder
    logic [sem_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                       r_qneg, n_qneg;
    logic                       r_done, n_done;
    sem_pkg::t_err              r_err, n_err;
    logic [sem_pkg::DATA_W-1:0] r_res, n_res;

    logic [sem_pkg::DATA_W:0]   w_add_x;
    logic [sem_pkg::DATA_W:0]   w_add_y;
    logic                       w_cin;
    logic [sem_pkg::DATA_W:0]   w_sum;
    logic [sem_pkg::DATA_W-1:0] w_shift;
    logic                       w_lt;
    logic                       w_eq;

    // partial remainder shifted by one with the next dividend bit
    assign w_shift = {r_acc[sem_pkg::DATA_W-2:0], r_x[sem_pkg::DATA_W-1]};

    // the one shared adder
    assign w_sum = w_add_x + w_add_y + {{sem_pkg::DATA_W{1'b0}}, w_cin};
    assign w_lt  = w_sum[sem_pkg::DATA_W];
    assign w_eq  = (r_x == r_y);

    // adder operand selection per step
    always_comb begin
        w_add_x = '0;
        w_add_y = '0;
        w_cin   = 1'b0;
        unique case (r_st)
            sem_pkg::A_SIMPLE: begin
                w_add_x = {r_x[sem_pkg::DATA_W-1], r_x};
                if (r_op == sem_pkg::ALU_ADD) begin
                    w_add_y = {r_y[sem_pkg::DATA_W-1], r_y};
                end else begin
                    w_add_y = ~{r_y[sem_pkg::DATA_W-1], r_y};
                    w_cin   = 1'b1;
                end
            end
            sem_pkg::A_MUL: begin
                w_add_x = {1'b0, r_acc};
                w_add_y = r_x[0] ? {1'b0, r_y} : '0;
            end
            sem_pkg::A_ABS_B, sem_pkg::A_SIGN: begin
                w_add_x = ~{1'b0, r_x};
                w_cin   = 1'b1;
            end
            sem_pkg::A_ABS_A: begin
                w_add_x = ~{1'b0, r_y};
                w_cin   = 1'b1;
            end
            sem_pkg::A_DIV: begin
                w_add_x = {1'b0, w_shift};
                w_add_y = ~{1'b0, r_y};
                w_cin   = 1'b1;
            end
            default: begin
                w_add_x = '0;
            end
        endcase
    end

    // sequencer of the unit
    always_comb begin
        n_st   = r_st;
        n_op   = r_op;
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_qneg = r_qneg;
        n_done = 1'b0;
        n_err  = r_err;
        n_res  = r_res;
        unique case (r_st)
            sem_pkg::A_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_x   = i_b;
                    n_y   = i_a;
                    n_acc = '0;
                    n_cnt = '0;
                    n_err = sem_pkg::ERR_OK;
                    n_res = '0;
                    if (i_req.op == sem_pkg::ALU_DIV) begin
                        if (i_a == '0) begin
                            n_err  = sem_pkg::ERR_DIV_ZERO;
                            n_done = 1'b1;
                        end else if (i_b == sem_pkg::DATA_MIN && i_a == '1) begin
                            n_err  = sem_pkg::ERR_DIV_OVF;
                            n_done = 1'b1;
                        end else begin
                            n_qneg = i_b[sem_pkg::DATA_W-1] ^ i_a[sem_pkg::DATA_W-1];
                            n_st   = sem_pkg::A_ABS_B;
                        end
                    end else if (i_req.op == sem_pkg::ALU_MUL) begin
                        n_st = sem_pkg::A_MUL;
                    end else begin
                        n_st = sem_pkg::A_SIMPLE;
                    end
                end
            end
            sem_pkg::A_SIMPLE: begin
                unique case (r_op)
                    sem_pkg::ALU_GT: n_res = {{(sem_pkg::DATA_W-1){1'b0}}, !w_lt && !w_eq};
                    sem_pkg::ALU_LT: n_res = {{(sem_pkg::DATA_W-1){1'b0}}, w_lt};
                    sem_pkg::ALU_LE: n_res = {{(sem_pkg::DATA_W-1){1'b0}}, w_lt || w_eq};
                    sem_pkg::ALU_GE: n_res = {{(sem_pkg::DATA_W-1){1'b0}}, !w_lt};
                    sem_pkg::ALU_EQ: n_res = {{(sem_pkg::DATA_W-1){1'b0}}, w_eq};
                    sem_pkg::ALU_NE: n_res = {{(sem_pkg::DATA_W-1){1'b0}}, !w_eq};
                    default:         n_res = w_sum[sem_pkg::DATA_W-1:0];
                endcase
                n_done = 1'b1;
                n_st   = sem_pkg::A_IDLE;
            end
            sem_pkg::A_MUL: begin
                // one multiplier bit per step, low word kept
                n_acc = w_sum[sem_pkg::DATA_W-1:0];
                n_x   = r_x >> 1;
                n_y   = r_y << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_res  = w_sum[sem_pkg::DATA_W-1:0];
                    n_done = 1'b1;
                    n_st   = sem_pkg::A_IDLE;
                end
            end
            sem_pkg::A_ABS_B: begin
                if (r_x[sem_pkg::DATA_W-1]) begin
                    n_x = w_sum[sem_pkg::DATA_W-1:0];
                end
                n_st = sem_pkg::A_ABS_A;
            end
            sem_pkg::A_ABS_A: begin
                if (r_y[sem_pkg::DATA_W-1]) begin
                    n_y = w_sum[sem_pkg::DATA_W-1:0];
                end
                n_st = sem_pkg::A_DIV;
            end
            sem_pkg::A_DIV: begin
                // restoring step: keep the difference when it is not negative
                n_acc = w_lt ? w_shift : w_sum[sem_pkg::DATA_W-1:0];
                n_x   = {r_x[sem_pkg::DATA_W-2:0], !w_lt};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_st = sem_pkg::A_SIGN;
                end
            end
            sem_pkg::A_SIGN: begin
                n_res  = r_qneg ? w_sum[sem_pkg::DATA_W-1:0] : r_x;
                n_done = 1'b1;
                n_st   = sem_pkg::A_IDLE;
            end
            default: begin
                n_st = sem_pkg::A_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= sem_pkg::A_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    // operand and result registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_x    <= n_x;
        r_y    <= n_y;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_qneg <= n_qneg;
        r_err  <= n_err;
        r_res  <= n_res;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.err  = r_err;
    assign o_result   = r_res;

endmodule

### sv/stack_expression_machine_core.sv
// Top level of the stack expression machine: stream ports, sequencer, operand
// stack memory and variable file. Depends on sem_pkg and sem_alu.
`timescale 1ns / 1ps

// One operation is taken per transfer on the slave side and gives exactly one
// result transfer on the master side. The block takes a new operation only
// once the previous one has finished; a finished result may still wait in the
// output register while the next operation is taken. Multiply and divide take
// longest, as the shared ALU retires one multiplier or quotient bit per cycle
// through its single adder. The operand stack is a 64-entry memory with one
// registered read port, so a binary operation fetches its two operands one
// after the other. Faults (underflow, overflow, divide by zero, divide
// overflow) leave the stack, its depth and the variables untouched and report
// the current depth.

module stack_expression_machine_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // literal_value [31:0], var_index [36:32], zero fill
    input  logic [sem_pkg::IN_W-1:0]  s_axis_tdata,
    // action [3:0]
    input  logic [sem_pkg::ACTION_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // value [31:0], condition [32], error [35:33], depth_now [42:36], zero fill
    output logic [sem_pkg::OUT_W-1:0] m_axis_tdata
);

    sem_pkg::t_state               r_state, n_state;
    sem_pkg::t_action              r_action, n_action;
    logic [sem_pkg::DATA_W-1:0]    r_lit, n_lit;
    logic [sem_pkg::VAR_IDX_W-1:0] r_vi, n_vi;
    logic [sem_pkg::STACK_CW-1:0]  r_count, n_count;
    logic [sem_pkg::DATA_W-1:0]    r_a, n_a;
    logic [sem_pkg::DATA_W-1:0]    r_value, n_value;
    logic                          r_cond, n_cond;
    sem_pkg::t_err                 r_err, n_err;
    logic                          r_out_valid, n_out_valid;
    logic [sem_pkg::OUT_W-1:0]     r_out_data, n_out_data;

    logic [sem_pkg::DATA_W-1:0]    r_stack [sem_pkg::STACK_DEPTH];
    logic [sem_pkg::DATA_W-1:0]    r_rd_data;
    logic [sem_pkg::DATA_W-1:0]    r_vars [sem_pkg::VAR_COUNT];

    logic                          w_accept;
    sem_pkg::t_action              w_in_action;
    logic [sem_pkg::STACK_CW-1:0]  w_cnt_m1;
    logic [sem_pkg::STACK_CW-1:0]  w_cnt_m2;
    logic                          w_rd_en;
    logic [sem_pkg::STACK_AW-1:0]  w_rd_addr;
    logic                          w_wr_en;
    logic [sem_pkg::STACK_AW-1:0]  w_wr_addr;
    logic [sem_pkg::DATA_W-1:0]    w_wr_data;
    logic                          w_vi_ok;
    logic                          w_var_we;
    logic [sem_pkg::DATA_W-1:0]    w_var_rd;
    sem_pkg::t_alu_req             w_alu_req;
    sem_pkg::t_alu_rsp             w_alu_rsp;
    logic [sem_pkg::DATA_W-1:0]    w_alu_res;

    // handshake and input unpacking
    assign s_axis_tready = (r_state == sem_pkg::S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_in_action   = sem_pkg::t_action'(s_axis_tuser);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_cnt_m1 = r_count - sem_pkg::STACK_CW'(1);
    assign w_cnt_m2 = r_count - sem_pkg::STACK_CW'(2);

    // variable lookup, out-of-range index reads as zero
    assign w_vi_ok  = (r_vi < sem_pkg::VAR_IDX_W'(sem_pkg::VAR_COUNT));
    assign w_var_rd = w_vi_ok ? r_vars[r_vi[sem_pkg::VAR_AW-1:0]] : '0;

    sem_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (r_a),
        .i_b      (r_rd_data),
        .o_rsp    (w_alu_rsp),
        .o_result (w_alu_res)
    );

    // sequencer: next state, stack and variable accesses
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_lit       = r_lit;
        n_vi        = r_vi;
        n_count     = r_count;
        n_a         = r_a;
        n_value     = r_value;
        n_cond      = r_cond;
        n_err       = r_err;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_cnt_m1[sem_pkg::STACK_AW-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = r_count[sem_pkg::STACK_AW-1:0];
        w_wr_data   = r_lit;
        w_var_we    = 1'b0;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = sem_pkg::action_to_op(r_action);
        unique case (r_state)
            sem_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_action = w_in_action;
                    n_lit    = s_axis_tdata[sem_pkg::DATA_W-1:0];
                    n_vi     = s_axis_tdata[sem_pkg::DATA_W +: sem_pkg::VAR_IDX_W];
                    n_value  = '0;
                    n_cond   = 1'b0;
                    n_err    = sem_pkg::ERR_OK;
                    if (w_in_action == sem_pkg::ACT_PUSH_LIT
                            || w_in_action == sem_pkg::ACT_PUSH_VAR) begin
                        if (r_count >= sem_pkg::STACK_CW'(sem_pkg::STACK_DEPTH)) begin
                            n_err   = sem_pkg::ERR_OVER;
                            n_state = sem_pkg::S_DONE;
                        end else begin
                            n_state = sem_pkg::S_PUSH;
                        end
                    end else if (w_in_action == sem_pkg::ACT_STORE
                            || w_in_action == sem_pkg::ACT_TEST
                            || w_in_action == sem_pkg::ACT_POP
                            || w_in_action == sem_pkg::ACT_PEEK) begin
                        if (r_count == '0) begin
                            n_err   = sem_pkg::ERR_UNDER;
                            n_state = sem_pkg::S_DONE;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = sem_pkg::S_READ_A;
                        end
                    end else begin
                        if (r_count < sem_pkg::STACK_CW'(2)) begin
                            n_err   = sem_pkg::ERR_UNDER;
                            n_state = sem_pkg::S_DONE;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = sem_pkg::S_READ_A;
                        end
                    end
                end
            end
            sem_pkg::S_PUSH: begin
                w_wr_en   = 1'b1;
                w_wr_data = (r_action == sem_pkg::ACT_PUSH_VAR) ? w_var_rd : r_lit;
                n_count   = r_count + sem_pkg::STACK_CW'(1);
                n_state   = sem_pkg::S_DONE;
            end
            sem_pkg::S_READ_A: begin
                // top of stack has arrived
                n_a     = r_rd_data;
                n_state = sem_pkg::S_DONE;
                unique case (r_action)
                    sem_pkg::ACT_STORE: begin
                        w_var_we = w_vi_ok;
                        n_count  = w_cnt_m1;
                    end
                    sem_pkg::ACT_TEST: begin
                        n_cond  = (r_rd_data == sem_pkg::DATA_W'(1));
                        n_count = w_cnt_m1;
                    end
                    sem_pkg::ACT_POP: begin
                        n_value = r_rd_data;
                        n_count = w_cnt_m1;
                    end
                    sem_pkg::ACT_PEEK: begin
                        n_value = r_rd_data;
                    end
                    default: begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_cnt_m2[sem_pkg::STACK_AW-1:0];
                        n_state   = sem_pkg::S_READ_B;
                    end
                endcase
            end
            sem_pkg::S_READ_B: begin
                w_alu_req.start = 1'b1;
                n_state         = sem_pkg::S_ALU;
            end
            sem_pkg::S_ALU: begin
                if (w_alu_rsp.done) begin
                    n_state = sem_pkg::S_DONE;
                    if (w_alu_rsp.err != sem_pkg::ERR_OK) begin
                        n_err = w_alu_rsp.err;
                    end else begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = w_cnt_m2[sem_pkg::STACK_AW-1:0];
                        w_wr_data = w_alu_res;
                        n_count   = w_cnt_m1;
                    end
                end
            end
            sem_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{(sem_pkg::OUT_W - sem_pkg::OUT_RAW){1'b0}},
                                   r_count, r_err, r_cond, r_value};
                    n_state     = sem_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sem_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sem_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_lit      <= n_lit;
        r_vi       <= n_vi;
        r_a        <= n_a;
        r_value    <= n_value;
        r_cond     <= n_cond;
        r_err      <= n_err;
        r_out_data <= n_out_data;
    end

    // operand stack memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_stack[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_stack[w_rd_addr];
        end
    end

    // variable file, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sem_pkg::VAR_COUNT; i++) begin
                r_vars[i] <= '0;
            end
        end else if (w_var_we) begin
            r_vars[r_vi[sem_pkg::VAR_AW-1:0]] <= r_rd_data;
        end
    end

    // depth never exceeds the stack size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sem_pkg::STACK_CW'(sem_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    // the alu only reports while the sequencer waits for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> (r_state == sem_pkg::S_ALU))
        else $error("alu done outside of alu wait");

    // one operation at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("ready right after a transfer");

    // an alu fault leaves the depth untouched
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sem_pkg::S_ALU && w_alu_rsp.done && w_alu_rsp.err != sem_pkg::ERR_OK)
        |=> $stable(r_count))
        else $error("depth changed on alu fault");

endmodule
